// ===== rtl/cordic_vectoring_polar_top_defines.svh =====
// Assertion macros shared by the CORDIC vectoring polar RTL.
`ifndef CORDIC_VECTORING_POLAR_TOP_DEFINES_SVH
`define CORDIC_VECTORING_POLAR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define CVP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define CVP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cvp_pkg.sv =====
// Types, constants and arctangent table for the CORDIC vectoring pipeline.
package cvp_pkg;

    // Internal datapath widths
    localparam int XY_W  = 33;
    localparam int ANG_W = 18;
    localparam int IN_W  = 30;
    localparam int OUT_W = 32;

    // Table depth and gain compensation
    localparam int ATAN_ENTRIES = 16;
    localparam int FRAC_BITS    = 16;
    localparam logic [16:0] GAIN_COMP = 17'd39796;
    localparam int PROD_W = OUT_W + 17;

    // Vector state carried down the pipeline
    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] ang;
    } cvp_vec_t;

    // atan(2^-i) in Q16, truncated
    function automatic logic signed [ANG_W-1:0] atan_q16(input int unsigned idx);
        logic signed [ANG_W-1:0] val;
        begin
            case (idx)
                0:       val = 18'sd51471;
                1:       val = 18'sd30385;
                2:       val = 18'sd16054;
                3:       val = 18'sd8149;
                4:       val = 18'sd4090;
                5:       val = 18'sd2047;
                6:       val = 18'sd1023;
                7:       val = 18'sd511;
                8:       val = 18'sd255;
                9:       val = 18'sd127;
                10:      val = 18'sd63;
                11:      val = 18'sd31;
                12:      val = 18'sd15;
                13:      val = 18'sd7;
                14:      val = 18'sd3;
                15:      val = 18'sd1;
                default: val = 18'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== rtl/cvp_stage.sv =====
// One CORDIC vectoring micro-rotation with its pipeline register.
`include "cordic_vectoring_polar_top_defines.svh"

module cvp_stage
    import cvp_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cvp_vec_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cvp_vec_t out_data
);

    localparam logic signed [ANG_W-1:0] ATAN_VAL = atan_q16(SHIFT);
    localparam logic signed [ANG_W-1:0] ATAN_NEG = -ATAN_VAL;

    logic                    valid_reg;
    cvp_vec_t                data_reg;
    cvp_vec_t                data_next;
    logic signed [XY_W-1:0]  x_src;
    logic signed [XY_W-1:0]  y_src;

    // Rotate toward the positive x axis; negate before the shift
    always_comb
    begin
        if (!in_data.y[XY_W-1])
        begin
            x_src         = -in_data.x;
            y_src         = -in_data.y;
            data_next.ang = in_data.ang + ATAN_VAL;
        end
        else
        begin
            x_src         = in_data.x;
            y_src         = in_data.y;
            data_next.ang = in_data.ang - ATAN_VAL;
        end
        data_next.x = in_data.x - (y_src >>> SHIFT);
        data_next.y = in_data.y + (x_src >>> SHIFT);
    end

    // Advance when this slot is empty or downstream takes its transaction
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load payload only on an accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `CVP_ASSERT_NXT(a_load_sets_valid, in_valid && in_ready, out_valid, "stage lost a transaction")
    `CVP_ASSERT_IMP(a_empty_ready, !out_valid, in_ready, "empty stage refused input")
    `CVP_ASSERT_NXT(a_angle_step, in_valid && in_ready, (ANG_W'(out_data.ang - $past(in_data.ang)) == ATAN_VAL) || (ANG_W'(out_data.ang - $past(in_data.ang)) == ATAN_NEG), "angle step is not the table entry")

endmodule

// ===== rtl/cvp_gain.sv =====
// Gain compensation multiply and output register.
module cvp_gain
    import cvp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  cvp_vec_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  raw_magnitude,
    output logic signed [OUT_W-1:0]  magnitude,
    output logic signed [ANG_W-1:0]  angle
);

    logic                           valid_reg;
    logic signed [OUT_W-1:0]        raw_reg;
    logic signed [ANG_W-1:0]        ang_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [OUT_W-1:0]        raw_next;
    logic signed [PROD_W-1:0]       prod_next;

    // Truncate final x to 32 bits and scale by the inverse gain
    assign raw_next  = in_data.x[OUT_W-1:0];
    assign prod_next = raw_next * $signed({1'b0, GAIN_COMP});

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold results until the transaction is taken
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            raw_reg  <= raw_next;
            prod_reg <= prod_next;
            ang_reg  <= in_data.ang;
        end
    end

    assign out_valid     = valid_reg;
    assign raw_magnitude = raw_reg;
    assign magnitude     = prod_reg[FRAC_BITS+OUT_W-1:FRAC_BITS];
    assign angle         = ang_reg;

endmodule

// ===== rtl/cordic_vectoring_polar_top.sv =====
// CORDIC vectoring unit: Cartesian Q16 point to raw magnitude, magnitude and angle.
// One register per micro-rotation and one for the gain multiply; each holds one transaction.
// Throughput: one point per cycle unless out_ready stalls the output; stalls collapse bubbles.
// Reset: asynchronous active-low clears all stage valid bits; payload registers are not reset.
// The datapath has no stored state beyond the pipeline, so no clearing pass is needed.
`include "cordic_vectoring_polar_top_defines.svh"

module cordic_vectoring_polar_top
    import cvp_pkg::*;
#(
    parameter int ITERATIONS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [IN_W-1:0]   coord_x,
    input  logic signed [IN_W-1:0]   coord_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  raw_magnitude,
    output logic signed [OUT_W-1:0]  magnitude,
    output logic signed [ANG_W-1:0]  angle
);

    localparam int STAGES = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;

    cvp_vec_t stage_data  [STAGES+1];
    logic     stage_valid [STAGES+1];
    logic     stage_ready [STAGES+1];

    // Sign-extend the input point into the datapath
    assign stage_data[0].x   = {{(XY_W-IN_W){coord_x[IN_W-1]}}, coord_x};
    assign stage_data[0].y   = {{(XY_W-IN_W){coord_y[IN_W-1]}}, coord_y};
    assign stage_data[0].ang = '0;
    assign stage_valid[0]    = in_valid;
    assign in_ready          = stage_ready[0];

    // One micro-rotation per stage
    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        cvp_stage #(
            .SHIFT (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    // Gain compensation and output register
    cvp_gain u_gain (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (stage_valid[STAGES]),
        .in_ready      (stage_ready[STAGES]),
        .in_data       (stage_data[STAGES]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .raw_magnitude (raw_magnitude),
        .magnitude     (magnitude),
        .angle         (angle)
    );

    `CVP_ASSERT_IMP(a_full_only_when_stalled, !in_ready, out_valid && !out_ready, "input stalled with a bubble in the pipe")
    `CVP_ASSERT_NXT(a_last_stage_feeds_out, stage_valid[STAGES] && stage_ready[STAGES], out_valid, "gain stage lost a transaction")
    `CVP_ASSERT_NXT(a_drain_clears_out, out_valid && out_ready && !stage_valid[STAGES], !out_valid, "output repeated a transaction")

endmodule
